// File: hw/rtl/dtw_pkg.sv
// ---------------------------------------------------------------------------
// dtw_pkg
// shared types and constants for the decision tree walk engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtw_pkg;

   localparam int MaxNodesDefault    = 256;
   localparam int MaxFeaturesDefault = 64;
   localparam int ValueBitsDefault   = 32;

   localparam int IdBits    = 8;
   localparam int FidxBits  = 6;
   localparam int CountBits = 9;

   typedef enum logic [1:0] {
      MODE_ROW   = 2'd0,
      MODE_FEAT  = 2'd1,
      MODE_WALK  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_CHILD = 2'd1,
      STATUS_TOO_LONG = 2'd2,
      STATUS_UNUSED   = 2'd3
   } status_type;

   // node row payload except the threshold
   typedef struct packed {
      logic                leaf;
      logic [FidxBits-1:0] fidx;
      logic [IdBits-1:0]   yes_id;
      logic [IdBits-1:0]   no_id;
      logic [IdBits-1:0]   miss_id;
   } row_type;

endpackage

`default_nettype wire

// File: hw/rtl/decision_tree_walk.sv
// ---------------------------------------------------------------------------
// decision_tree_walk
// node table and feature store in synchronous memories, walked by a sequencer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Mode 0 and mode 1 requests write one node row or one feature in the cycle
// they are taken and keep busy low. A mode 2 request walks the tree from row
// 0 and raises rsp_valid for exactly one cycle with the leaf id and status;
// the receiver cannot stall it. Each inner level reads the row and its
// feature, then does one node id memory read per searched row, with lim =
// min(node_count, MAX_NODES) rows searched, since the single read port of
// the id memory scans the table for the child id. No clearing pass is
// needed after reset.
module decision_tree_walk #(
   parameter int MAX_NODES    = dtw_pkg::MaxNodesDefault,
   parameter int MAX_FEATURES = dtw_pkg::MaxFeaturesDefault,
   parameter int VALUE_BITS   = dtw_pkg::ValueBitsDefault
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request transfer
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_mode,
   input  wire logic [7:0]                   req_row_index,
   input  wire logic [dtw_pkg::IdBits-1:0]   req_node_id,
   input  wire logic                         req_leaf_flag,
   input  wire logic [dtw_pkg::FidxBits-1:0] req_feature_index,
   input  wire logic signed [31:0]           req_threshold,
   input  wire logic [dtw_pkg::IdBits-1:0]   req_yes_child,
   input  wire logic [dtw_pkg::IdBits-1:0]   req_no_child,
   input  wire logic [dtw_pkg::IdBits-1:0]   req_missing_child,
   input  wire logic signed [31:0]           req_feature_value,
   input  wire logic                         req_value_absent,
   // result transfer
   output logic                              rsp_valid,
   output logic [dtw_pkg::IdBits-1:0]        rsp_leaf_node,
   output logic [1:0]                        rsp_walk_status,
   // node_count register
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [dtw_pkg::CountBits-1:0] csr_data
);

   localparam int NodeAw  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int FeatAw  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CntBits = $clog2(MAX_NODES + 1);
   localparam int LimW    = (CntBits > dtw_pkg::CountBits) ? CntBits : dtw_pkg::CountBits;
   localparam int RowXw   = (NodeAw > 8) ? NodeAw : 8;
   localparam int FeatXw  = (FeatAw > dtw_pkg::FidxBits) ? FeatAw : dtw_pkg::FidxBits;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,    // row read in flight
      ST_EVAL,    // row data valid, feature read issued
      ST_PICK,    // feature data valid, child chosen
      ST_SCAN     // id memory sweep
   } state_type;

   // memories
   dtw_pkg::row_type        row_mem   [MAX_NODES];
   logic [VALUE_BITS-1:0]   thr_mem   [MAX_NODES];
   logic [dtw_pkg::IdBits-1:0] id_mem [MAX_NODES];
   logic [VALUE_BITS:0]     feat_mem  [MAX_FEATURES];   // {absent, value}
   logic [MAX_FEATURES-1:0] feat_written_ff;            // unwritten reads as absent

   state_type                  state_ff;
   logic [LimW-1:0]            count_ff;
   logic [NodeAw-1:0]          row_ff;
   logic [dtw_pkg::IdBits-1:0] node_ff;
   logic [LimW-1:0]            steps_ff;
   logic [LimW-1:0]            scan_ff;
   logic                       pend_ff;
   logic [NodeAw-1:0]          pend_idx_ff;
   logic                       hit_ff;
   logic [NodeAw-1:0]          hit_row_ff;
   logic                       frange_ff;
   logic [FeatAw-1:0]          fsel_ff;
   logic                       rsp_valid_ff;
   logic [dtw_pkg::IdBits-1:0] rsp_leaf_ff;
   dtw_pkg::status_type        rsp_status_ff;

   // memory read data
   dtw_pkg::row_type           row_q;
   logic [VALUE_BITS-1:0]      thr_q;
   logic [dtw_pkg::IdBits-1:0] id_q;
   logic [VALUE_BITS:0]        feat_q;

   logic                       accept;
   logic [RowXw-1:0]           wrow_x;
   logic [FeatXw-1:0]          wfeat_x;
   logic [FeatXw-1:0]          rfeat_x;
   logic [LimW-1:0]            lim;
   logic [LimW-1:0]            scan_in;
   logic [dtw_pkg::IdBits-1:0] child_in;
   logic                       absent;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign wrow_x  = RowXw'(req_row_index);
   assign wfeat_x = FeatXw'(req_feature_index);
   assign rfeat_x = FeatXw'(row_q.fidx);

   // effective row count, saturated at the table depth
   assign lim = (count_ff > LimW'(MAX_NODES)) ? LimW'(MAX_NODES) : count_ff;

   assign scan_in = scan_ff + LimW'(1);

   // feature out of range or never written is absent
   assign absent = !frange_ff || !feat_written_ff[fsel_ff] || feat_q[VALUE_BITS];

   always_comb begin
      if (absent) begin
         child_in = row_q.miss_id;
      end else if ($signed(feat_q[VALUE_BITS-1:0]) < $signed(thr_q)) begin
         child_in = row_q.yes_id;
      end else begin
         child_in = row_q.no_id;
      end
   end

   // node table: row payload read at the current row, node id at the scan index
   always_ff @(posedge clock) begin
      if (accept && req_mode == dtw_pkg::MODE_ROW && int'(wrow_x) < MAX_NODES) begin
         row_mem[wrow_x[NodeAw-1:0]] <= '{leaf: req_leaf_flag, fidx: req_feature_index,
                                          yes_id: req_yes_child, no_id: req_no_child,
                                          miss_id: req_missing_child};
         thr_mem[wrow_x[NodeAw-1:0]] <= VALUE_BITS'(req_threshold);
         id_mem[wrow_x[NodeAw-1:0]]  <= req_node_id;
      end
      row_q <= row_mem[row_ff];
      thr_q <= thr_mem[row_ff];
      id_q  <= id_mem[scan_ff[NodeAw-1:0]];
   end

   // feature store: read at the feature the current row tests
   always_ff @(posedge clock) begin
      if (accept && req_mode == dtw_pkg::MODE_FEAT && int'(wfeat_x) < MAX_FEATURES) begin
         feat_mem[wfeat_x[FeatAw-1:0]] <= {req_value_absent, VALUE_BITS'(req_feature_value)};
      end
      feat_q <= feat_mem[rfeat_x[FeatAw-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feat_written_ff <= '0;
      end else if (accept && req_mode == dtw_pkg::MODE_FEAT &&
                   int'(wfeat_x) < MAX_FEATURES) begin
         feat_written_ff[wfeat_x[FeatAw-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= LimW'(1);
      end else if (csr_valid && csr_ready) begin
         count_ff <= LimW'(csr_data);
      end
   end

   // walk sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         row_ff        <= '0;
         node_ff       <= '0;
         steps_ff      <= '0;
         scan_ff       <= '0;
         pend_idx_ff   <= '0;
         hit_row_ff    <= '0;
         frange_ff     <= 1'b0;
         fsel_ff       <= '0;
         rsp_leaf_ff   <= '0;
         rsp_status_ff <= dtw_pkg::STATUS_OK;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_mode == dtw_pkg::MODE_WALK) begin
                  row_ff   <= '0;
                  node_ff  <= '0;
                  steps_ff <= '0;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               // row data valid, feature read of row_q.fidx is issued now
               frange_ff <= int'(rfeat_x) < MAX_FEATURES;
               fsel_ff   <= rfeat_x[FeatAw-1:0];
               if (row_q.leaf) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_leaf_ff   <= node_ff;
                  rsp_status_ff <= dtw_pkg::STATUS_OK;
                  state_ff      <= ST_IDLE;
               end else if (steps_ff >= lim) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_leaf_ff   <= '0;
                  rsp_status_ff <= dtw_pkg::STATUS_TOO_LONG;
                  state_ff      <= ST_IDLE;
               end else begin
                  state_ff <= ST_PICK;
               end
            end
            ST_PICK: begin
               node_ff  <= child_in;
               steps_ff <= steps_ff + LimW'(1);
               scan_ff  <= '0;
               pend_ff  <= 1'b0;
               hit_ff   <= 1'b0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               // compare the id read in the previous cycle, keep the last match
               if (pend_ff && id_q == node_ff) begin
                  hit_ff     <= 1'b1;
                  hit_row_ff <= pend_idx_ff;
               end
               if (scan_ff < lim) begin
                  pend_ff     <= 1'b1;
                  pend_idx_ff <= scan_ff[NodeAw-1:0];
                  scan_ff     <= scan_in;
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     if (hit_ff) begin
                        row_ff   <= hit_row_ff;
                        state_ff <= ST_LOAD;
                     end else begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_leaf_ff   <= '0;
                        rsp_status_ff <= dtw_pkg::STATUS_NO_CHILD;
                        state_ff      <= ST_IDLE;
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_leaf_node   = rsp_leaf_ff;
   assign rsp_walk_status = rsp_status_ff;

   // every finished walk leaves exactly one result
   a_end_has_rsp : assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("walk ended without result");

   // error results carry leaf id zero
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_walk_status != dtw_pkg::STATUS_OK |-> rsp_leaf_node == '0)
      else $error("error result with nonzero leaf");

   // sweep never runs past the searched rows
   a_scan_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> scan_ff <= lim) else $error("scan past limit");

   // step count stays within the limit
   a_steps : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> steps_ff <= lim) else $error("step count past limit");

endmodule

`default_nettype wire

// File: bench/decision_tree_walk_test.sv
// ---------------------------------------------------------------------------
// decision_tree_walk_test
// self-checking bench: loads node tables and features, runs tree walks and
// compares every result's leaf id and status to given values or a local walker
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module decision_tree_walk_test;

   localparam int NumRows   = 256;
   localparam int NumFeats  = 64;
   localparam int CycleStop = 10000000;

   typedef struct {
      dtw_pkg::mode_type mode;
      logic [7:0]  row_index;
      logic [7:0]  node_id;
      logic        leaf_flag;
      logic [5:0]  feature_index;
      logic [31:0] threshold;
      logic [7:0]  yes_child;
      logic [7:0]  no_child;
      logic [7:0]  missing_child;
      logic [31:0] feature_value;
      logic        value_absent;
   } req_item;

   typedef struct {
      logic [7:0]          leaf;
      dtw_pkg::status_type status;
   } walk_result;

   typedef struct {
      req_item    it;
      bit         typed;
      walk_result exp;
   } dir_row;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_mode = '0;
   logic [7:0]  req_row_index = '0;
   logic [7:0]  req_node_id = '0;
   logic        req_leaf_flag = 1'b0;
   logic [5:0]  req_feature_index = '0;
   logic signed [31:0] req_threshold = '0;
   logic [7:0]  req_yes_child = '0;
   logic [7:0]  req_no_child = '0;
   logic [7:0]  req_missing_child = '0;
   logic signed [31:0] req_feature_value = '0;
   logic        req_value_absent = 1'b0;
   logic        rsp_valid;
   logic [7:0]  rsp_leaf_node;
   logic [1:0]  rsp_walk_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [8:0]  csr_data = '0;

   // local copy of the node table, features and node_count
   logic [7:0]         tbl_id   [NumRows];
   logic               tbl_leaf [NumRows];
   logic [5:0]         tbl_fidx [NumRows];
   logic signed [31:0] tbl_thr  [NumRows];
   logic [7:0]         tbl_yes  [NumRows];
   logic [7:0]         tbl_no   [NumRows];
   logic [7:0]         tbl_miss [NumRows];
   bit                 row_written [NumRows];
   logic signed [31:0] feat_val [NumFeats];
   logic               feat_abs [NumFeats];
   int unsigned        node_count_sh = 1;

   walk_result  pending_walks[$];
   int          err_count = 0;
   int unsigned cycle_count = 0;

   decision_tree_walk DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_row_index(req_row_index), .req_node_id(req_node_id),
      .req_leaf_flag(req_leaf_flag), .req_feature_index(req_feature_index),
      .req_threshold(req_threshold), .req_yes_child(req_yes_child),
      .req_no_child(req_no_child), .req_missing_child(req_missing_child),
      .req_feature_value(req_feature_value), .req_value_absent(req_value_absent),
      .rsp_valid(rsp_valid), .rsp_leaf_node(rsp_leaf_node),
      .rsp_walk_status(rsp_walk_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleStop) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   // every strobed result is matched against the oldest pending walk
   always @(posedge clock) begin
      walk_result e;
      if (!reset && rsp_valid) begin
         if (pending_walks.size() == 0) begin
            report($sformatf("unexpected result leaf %0d status %0d",
                             rsp_leaf_node, rsp_walk_status));
         end else begin
            e = pending_walks.pop_front();
            if (rsp_leaf_node !== e.leaf)
               report($sformatf("leaf_node %0d, wanted %0d", rsp_leaf_node, e.leaf));
            if (rsp_walk_status !== e.status)
               report($sformatf("walk_status %0d, wanted %0d", rsp_walk_status, e.status));
         end
      end
   end

   function automatic req_item mk(dtw_pkg::mode_type m, int r, int id, bit lf, int fi,
                                  logic [31:0] thr, int y, int n, int ms,
                                  logic [31:0] v, bit ab);
      req_item it;
      it.mode = m;           it.row_index = 8'(r);  it.node_id = 8'(id);
      it.leaf_flag = lf;     it.feature_index = 6'(fi);
      it.threshold = thr;    it.yes_child = 8'(y);  it.no_child = 8'(n);
      it.missing_child = 8'(ms); it.feature_value = v; it.value_absent = ab;
      return it;
   endfunction

   // walk the local table from row 0 the way the engine should
   function automatic walk_result tree_walk();
      walk_result  r;
      int unsigned lim, steps, row;
      logic [7:0]  node;
      int          hit;
      lim = (node_count_sh > NumRows) ? NumRows : node_count_sh;
      row = 0;
      node = '0;
      steps = 0;
      r.status = dtw_pkg::STATUS_OK;
      while (1) begin
         if (tbl_leaf[row]) break;
         if (steps >= lim) begin
            r.status = dtw_pkg::STATUS_TOO_LONG;
            break;
         end
         steps++;
         if (feat_abs[tbl_fidx[row]])
            node = tbl_miss[row];
         else if (feat_val[tbl_fidx[row]] < tbl_thr[row])
            node = tbl_yes[row];
         else
            node = tbl_no[row];
         hit = -1;
         for (int k = 0; k < lim; k++)
            if (tbl_id[k] == node) hit = k;
         if (hit < 0) begin
            r.status = dtw_pkg::STATUS_NO_CHILD;
            break;
         end
         row = hit;
      end
      r.leaf = (r.status == dtw_pkg::STATUS_OK) ? node : 8'd0;
      return r;
   endfunction

   // a walk reads row 0 and scans rows below node_count, all must be loaded
   function automatic bit walk_safe();
      int unsigned lim;
      lim = (node_count_sh > NumRows) ? NumRows : node_count_sh;
      if (lim == 0) lim = 1;
      for (int k = 0; k < lim; k++)
         if (!row_written[k]) return 0;
      return 1;
   endfunction

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
      return $urandom_range(10, 60);
   endfunction

   // drive one request and hold it until the transfer; caller sits on an edge
   task automatic send(input req_item it, input int unsigned gap,
                       input bit typed, input walk_result exp);
      walk_result w;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_mode          <= it.mode;
      req_row_index     <= it.row_index;
      req_node_id       <= it.node_id;
      req_leaf_flag     <= it.leaf_flag;
      req_feature_index <= it.feature_index;
      req_threshold     <= it.threshold;
      req_yes_child     <= it.yes_child;
      req_no_child      <= it.no_child;
      req_missing_child <= it.missing_child;
      req_feature_value <= it.feature_value;
      req_value_absent  <= it.value_absent;
      @(posedge clock);
      while (busy) @(posedge clock);
      // transfer happened at this edge, update the local state in order
      case (it.mode)
         dtw_pkg::MODE_ROW: begin
            tbl_id[it.row_index]   = it.node_id;
            tbl_leaf[it.row_index] = it.leaf_flag;
            tbl_fidx[it.row_index] = it.feature_index;
            tbl_thr[it.row_index]  = it.threshold;
            tbl_yes[it.row_index]  = it.yes_child;
            tbl_no[it.row_index]   = it.no_child;
            tbl_miss[it.row_index] = it.missing_child;
            row_written[it.row_index] = 1;
         end
         dtw_pkg::MODE_FEAT: begin
            feat_val[it.feature_index] = it.feature_value;
            feat_abs[it.feature_index] = it.value_absent;
         end
         dtw_pkg::MODE_WALK: begin
            w = typed ? exp : tree_walk();
            pending_walks.push_back(w);
         end
         default: ;
      endcase
   endtask

   // drain all walks, then let the engine settle before touching node_count
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_walks.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_node_count(input int unsigned v);
      csr_valid <= 1'b1;
      csr_data  <= v[8:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      node_count_sh = v;
   endtask

   // random row that mostly links to ids present in the first rows
   function automatic req_item rand_row(int r, int unsigned span, int leaf_pct);
      int unsigned ids;
      logic [31:0] thr;
      ids = (span == 0) ? 1 : span;
      case ($urandom_range(0, 5))
         0: thr = 32'h8000_0000;
         1: thr = 32'h7FFF_FFFF;
         2: thr = $urandom_range(0, 65536 * 4) - 65536 * 2;
         default: thr = $urandom;
      endcase
      return mk(dtw_pkg::MODE_ROW, r,
                ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, ids - 1),
                ($urandom_range(0, 99) < leaf_pct),
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7),
                thr,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, ids - 1),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, ids - 1),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, ids - 1),
                $urandom, $urandom_range(0, 1));
   endfunction

   initial begin
      dir_row      dir_tbl[$];
      walk_result  none;
      int unsigned settings[$];
      int unsigned span, nops, gap_on, leaf_pct;
      req_item     it;
      int          sel;

      none.leaf = '0;
      none.status = dtw_pkg::STATUS_OK;
      for (int k = 0; k < NumRows; k++) row_written[k] = 0;
      for (int k = 0; k < NumFeats; k++) begin
         feat_abs[k] = 1'b1;
         feat_val[k] = '0;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, node_count is still 1 from reset
      dir_tbl.push_back('{mk(dtw_pkg::MODE_ROW, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0), 0, none});
      // root is a leaf
      dir_tbl.push_back('{mk(dtw_pkg::MODE_WALK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                          '{8'd0, dtw_pkg::STATUS_OK}});
      // inner root looping on itself with all features absent after reset
      dir_tbl.push_back('{mk(dtw_pkg::MODE_ROW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
      dir_tbl.push_back('{mk(dtw_pkg::MODE_WALK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                          '{8'd0, dtw_pkg::STATUS_TOO_LONG}});
      // missing child id that no row carries
      dir_tbl.push_back('{mk(dtw_pkg::MODE_ROW, 0, 0, 0, 0, 0, 0, 0, 9, 0, 0), 0, none});
      dir_tbl.push_back('{mk(dtw_pkg::MODE_WALK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                          '{8'd0, dtw_pkg::STATUS_NO_CHILD}});
      // signed compare at the extremes: yes loops, no is not found
      dir_tbl.push_back('{mk(dtw_pkg::MODE_FEAT, 0, 0, 0, 63, 0, 0, 0, 0, 32'h7FFF_FFFF, 0),
                          0, none});
      dir_tbl.push_back('{mk(dtw_pkg::MODE_ROW, 0, 0, 0, 63, 32'h8000_0000, 0, 7, 0, 0, 0),
                          0, none});
      dir_tbl.push_back('{mk(dtw_pkg::MODE_WALK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
      dir_tbl.push_back('{mk(dtw_pkg::MODE_ROW, 0, 0, 0, 63, 32'h7FFF_FFFF, 0, 7, 0, 0, 0),
                          0, none});
      dir_tbl.push_back('{mk(dtw_pkg::MODE_WALK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
      dir_tbl.push_back('{mk(dtw_pkg::MODE_FEAT, 0, 0, 0, 63, 0, 0, 0, 0, 32'h8000_0000, 0),
                          0, none});
      dir_tbl.push_back('{mk(dtw_pkg::MODE_WALK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
      // equal value goes to the no child
      dir_tbl.push_back('{mk(dtw_pkg::MODE_ROW, 0, 0, 0, 63, 32'h8000_0000, 0, 7, 0, 0, 0),
                          0, none});
      dir_tbl.push_back('{mk(dtw_pkg::MODE_WALK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
      // absent again, takes the missing child
      dir_tbl.push_back('{mk(dtw_pkg::MODE_FEAT, 0, 0, 0, 63, 0, 0, 0, 0, 32'hFFFF_FFFF, 1),
                          0, none});
      dir_tbl.push_back('{mk(dtw_pkg::MODE_WALK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
      // undefined mode with every field high does nothing
      dir_tbl.push_back('{mk(dtw_pkg::MODE_NONE, 255, 255, 1, 63, '1, 255, 255, 255, '1, 1),
                          0, none});
      dir_tbl.push_back('{mk(dtw_pkg::MODE_WALK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
      // top row with all fields high
      dir_tbl.push_back('{mk(dtw_pkg::MODE_ROW, 255, 255, 1, 63, '1, 255, 255, 255, 0, 0),
                          0, none});
      dir_tbl.push_back('{mk(dtw_pkg::MODE_WALK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});

      foreach (dir_tbl[i])
         send(dir_tbl[i].it, pick_gap(), dir_tbl[i].typed, dir_tbl[i].exp);

      // node_count settings, extremes included; 511 saturates to the table size
      settings = '{0, 1, 2, 3, 5, 8, 256, 12, 16, 4, 511, 7, 20, 10, 6};
      repeat (3) settings.push_back($urandom_range(1, 20));

      foreach (settings[p]) begin
         wait_idle();
         write_node_count(settings[p]);
         span = (settings[p] > NumRows) ? NumRows : settings[p];
         if (span == 0) span = 1;
         leaf_pct = (span > 32) ? 55 : 35;
         // fresh table over the searched rows, root mostly inner
         for (int r = 0; r < span; r++) begin
            it = rand_row(r, span, (r == 0) ? 10 : leaf_pct);
            send(it, 0, 0, none);
         end
         nops = (span > 32) ? 10 : 50;
         gap_on = (p % 4 != 2);
         for (int n = 0; n < nops; n++) begin
            sel = $urandom_range(0, 99);
            if (p == 1 && n == nops / 2) begin
               // hold off until every walk has come back
               start <= 1'b0;
               while (pending_walks.size() != 0) @(posedge clock);
            end
            if (span > 32 && sel < 50)
               sel = 0;
            if (sel < 45 && walk_safe())
               it = mk(dtw_pkg::MODE_WALK, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 1), $urandom_range(0, 63), $urandom,
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom, $urandom_range(0, 1));
            else if (sel < 75)
               it = mk(dtw_pkg::MODE_FEAT, $urandom_range(0, 255), $urandom_range(0, 255), 0,
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 7),
                       $urandom, 0, 0, 0, $urandom, ($urandom_range(0, 4) == 0));
            else if (sel < 85)
               it = rand_row($urandom_range(0, span - 1), span, leaf_pct);
            else if (sel < 90)
               it = rand_row($urandom_range(0, 255), span, leaf_pct);
            else
               it = mk(dtw_pkg::MODE_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 1), $urandom_range(0, 63), $urandom,
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom, $urandom_range(0, 1));
            send(it, gap_on ? pick_gap() : 0, 0, none);
         end
      end

      start <= 1'b0;
      while (pending_walks.size() != 0) @(posedge clock);
      // room for any stray late result
      repeat (400) @(posedge clock);
      if (err_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
